@@ design/frag_pkg.sv @@
`default_nettype none

package frag_pkg;

  // Default reassembly store size in bytes
  localparam int STORE_BYTES_DEF = 256;

  // Header layout: id, fragment index, total fragments, payload length
  localparam int HEADER_BYTES = 4;
  localparam int HDR_ID       = 0;
  localparam int HDR_INDEX    = 1;
  localparam int HDR_TOTAL    = 2;
  localparam int HDR_LENGTH   = 3;

  // Input commands
  localparam logic CMD_FRAME_BYTE = 1'b0;
  localparam logic CMD_READ_STORE = 1'b1;

  // Frame-end status codes
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_SHORT    = 3'd3,
    ST_SEQUENCE = 3'd4,
    ST_OVERFLOW = 3'd5
  } frame_status_t;

endpackage

`default_nettype wire

@@ design/frag_ram.sv @@
`default_nettype none

module frag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ design/fragment_reassembler_unit.sv @@
// Fragment reassembler.
// Input channel (in_valid/in_ready) carries one item per transfer: either a
// received frame byte (command 0, header of four bytes first, frame_last on
// the final byte) or a read of the reassembly store (command 1, read_index).
// Output channel (out_valid/out_ready) carries exactly one result per input
// item, in order: frame_status on a frame's last byte, message_length and
// message_source when a message completes, read_data for a store read; all
// other fields are zero.
// A result passes through stage 1 and then the output register: the transfer
// loads stage 1 while the store access is issued (single-port RAM, registered
// read), and stage 1 loads the output register once that register is free.
// Throughput is one item per cycle while the receiver takes results; the store
// port is used at most once per item, to write a payload byte or read a byte.
// When the receiver stalls, one result waits in the output register and one
// in the stage behind it; in_ready drops only when both are full.
// Reset (synchronous) clears sequence state, header position and both
// stages, and holds in_ready low. The store itself is not cleared; an
// unwritten entry reads as garbage. Items are taken right after reset.
`default_nettype none

module fragment_reassembler_unit
  import frag_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_last,
  input  wire logic [47:0] source_address,
  input  wire logic [7:0]  read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       frame_status,
  output logic [8:0]       message_length,
  output logic [47:0]      message_source,
  output logic [7:0]       read_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = $clog2(STORE_BYTES + 1);
  localparam int SW = ((LW > 8) ? LW : 8) + 1;
  localparam int IW = ((AW > 8) ? AW : 8) + 1;

  // Sequence state
  logic [LW-1:0] assembled_length, assembled_length_next;
  logic [7:0]    expected_index, expected_index_next;
  logic [7:0]    current_id, current_id_next;
  logic [2:0]    frame_position, frame_position_next;
  logic [7:0]    hdr [HEADER_BYTES];
  logic [7:0]    hdr_next [HEADER_BYTES];
  logic          fragment_ok, fragment_ok_next;
  logic [7:0]    payload_count, payload_count_next;

  // Stage 1 (store access) and output stage
  logic          s1_valid;
  logic          s1_adv;
  frame_status_t s1_status;
  logic [LW-1:0] s1_len;
  logic [47:0]   s1_src;
  logic          s1_read;
  logic          s1_inrange;

  logic          accept;
  frame_status_t status_w;
  logic [LW-1:0] mlen_w;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          rd_inrange;
  logic [SW-1:0] fit_sum;

  // Handshake
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  // Frame byte processing
  always_comb begin
    assembled_length_next = assembled_length;
    expected_index_next   = expected_index;
    current_id_next       = current_id;
    frame_position_next   = frame_position;
    hdr_next              = hdr;
    fragment_ok_next      = fragment_ok;
    payload_count_next    = payload_count;
    status_w              = ST_NONE;
    mlen_w                = '0;
    wr_en                 = 1'b0;
    wr_addr               = AW'(SW'(assembled_length) + SW'(payload_count));
    fit_sum               = '0;

    if (accept && command == CMD_FRAME_BYTE) begin
      if (frame_position < 3'(HEADER_BYTES)) begin
        hdr_next[frame_position[1:0]] = data_byte;
        frame_position_next = frame_position + 3'd1;
        if (frame_position_next == 3'(HEADER_BYTES)) begin
          // Index zero opens a new message
          if (hdr_next[HDR_INDEX] == 8'd0) begin
            current_id_next       = hdr_next[HDR_ID];
            expected_index_next   = 8'd0;
            assembled_length_next = '0;
          end
          fit_sum = SW'(assembled_length_next) + SW'(hdr_next[HDR_LENGTH]);
          fragment_ok_next = (hdr_next[HDR_ID] == current_id_next) &&
                             (hdr_next[HDR_INDEX] == expected_index_next) &&
                             (fit_sum <= SW'(STORE_BYTES));
          payload_count_next = 8'd0;
        end
      end else if (fragment_ok && payload_count < hdr[HDR_LENGTH]) begin
        // Payload byte; position always fits after the header check
        wr_en              = 1'b1;
        payload_count_next = payload_count + 8'd1;
      end

      if (frame_last) begin
        if (frame_position_next < 3'(HEADER_BYTES)) begin
          status_w = ST_SHORT;
        end else if (fragment_ok_next) begin
          assembled_length_next = LW'(SW'(assembled_length_next) +
                                      SW'(payload_count_next));
          expected_index_next   = expected_index_next + 8'd1;
          if (expected_index_next == hdr_next[HDR_TOTAL]) begin
            status_w              = ST_COMPLETE;
            mlen_w                = assembled_length_next;
            assembled_length_next = '0;
          end else begin
            status_w = ST_ACCEPTED;
          end
        end else begin
          status_w = ((hdr_next[HDR_ID] == current_id_next) &&
                      (hdr_next[HDR_INDEX] == expected_index_next)) ?
                     ST_OVERFLOW : ST_SEQUENCE;
          assembled_length_next = '0;
        end
        frame_position_next = 3'd0;
        fragment_ok_next    = 1'b0;
        payload_count_next  = 8'd0;
      end
    end
  end

  // Store port: at most one write or one read per item
  assign rd_en      = accept && (command == CMD_READ_STORE);
  assign rd_inrange = IW'(read_index) < IW'(STORE_BYTES);
  assign ram_addr   = rd_en ? AW'(read_index) : wr_addr;

  frag_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .re    (rd_en),
    .addr  (ram_addr),
    .wdata (data_byte),
    .rdata (ram_rdata)
  );

  // Sequence state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      assembled_length <= '0;
      expected_index   <= '0;
      current_id       <= '0;
      frame_position   <= '0;
      fragment_ok      <= 1'b0;
      payload_count    <= '0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        hdr[i] <= '0;
      end
    end else begin
      assembled_length <= assembled_length_next;
      expected_index   <= expected_index_next;
      current_id       <= current_id_next;
      frame_position   <= frame_position_next;
      fragment_ok      <= fragment_ok_next;
      payload_count    <= payload_count_next;
      hdr              <= hdr_next;
    end
  end

  // Stage 1: result held while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status  <= status_w;
      s1_len     <= mlen_w;
      s1_src     <= (status_w == ST_COMPLETE) ? source_address : 48'd0;
      s1_read    <= (command == CMD_READ_STORE);
      s1_inrange <= rd_inrange;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      frame_status   <= s1_status;
      message_length <= 9'(s1_len);
      message_source <= s1_src;
      read_data      <= (s1_read && s1_inrange) ? ram_rdata : 8'd0;
    end
  end

  // Checks
  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    frame_position <= 3'(HEADER_BYTES))
    else $error("frame position past header");

  a_len_range : assert property (@(posedge clk) disable iff (rst)
    SW'(assembled_length) <= SW'(STORE_BYTES))
    else $error("assembled length past store size");

  a_wr_range : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (SW'(assembled_length) + SW'(payload_count) < SW'(STORE_BYTES)))
    else $error("payload write beyond store");

  a_rd_hold : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !rd_en)
    else $error("store read while pending read data not consumed");

endmodule

`default_nettype wire
